// ===== sv/arithmetic_encoder_31bit_assert.svh =====
// Assertion macros used by the encoder back end.
`ifndef ARITHMETIC_ENCODER_31BIT_ASSERT_SVH
`define ARITHMETIC_ENCODER_31BIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define AE31_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// A condition in one cycle that forces another in the following cycle.
`define AE31_IMPLIES_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ae31_pkg.sv =====
package ae31_pkg;

    // Default width of the model's total count.
    localparam int COUNT_BITS_DEF = 20;

    // Field widths.
    localparam int CNT_W    = 21;
    localparam int FOLLOW_W = 16;
    localparam int IVL_W    = 31;

    // Interval boundaries.
    localparam logic [IVL_W-1:0] Q_FIRST = 31'h2000_0000;
    localparam logic [IVL_W-1:0] Q_HALF  = 31'h4000_0000;
    localparam logic [IVL_W-1:0] Q_THIRD = 31'h6000_0000;
    localparam logic [IVL_W-1:0] MASK31  = 31'h7FFF_FFFF;

    localparam logic [FOLLOW_W-1:0] PEND_MAX = 16'hFFFF;

    // Most results that one encode request may produce, and the renormalization bound.
    localparam logic [5:0] MAX_RES   = 6'd32;
    localparam logic [5:0] MAX_ITER  = 6'd40;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ENCODE,
        KIND_FLUSH,
        KIND_ERROR
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [CNT_W-1:0] low_count;
        logic [CNT_W-1:0] high_count;
        logic [CNT_W-1:0] total_freq;
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_UPDATE,
        ST_RENORM,
        ST_LAST,
        ST_FLUSH,
        ST_ERROR
    } t_state;

endpackage

// ===== sv/arithmetic_encoder_31bit.sv =====
// 31-bit binary arithmetic encoder. A request is either an encode of the
// cumulative interval low_count..high_count out of the model's total frequency,
// or a flush. A front stage classifies each request (encode, flush, or illegal
// interval) and queues it two deep; the back end then runs it. An encode steps
// through dequeue, the shared 32x21 multiplier (low count, then high count),
// the pair of bit-serial dividers, an interval update, the E1/E2/E3
// renormalization steps (at most 40), a check that no step applies, and the
// release of the final bit. Each decided bit, up to 32 per request, is a result
// with the count of inverted bits that follow it; the last result of a request
// carries last. An encode with no decided bit returns nothing. A flush or an
// illegal interval gives one result. Results are stored in an output register
// so the coder keeps working while a result waits; it stalls whenever a result
// must move into the output register while that register is still occupied.
module arithmetic_encoder_31bit #(
    parameter int COUNT_BITS = ae31_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [ae31_pkg::CNT_W-1:0]    i_low_count,
    input  logic [ae31_pkg::CNT_W-1:0]    i_high_count,
    input  logic [ae31_pkg::CNT_W-1:0]    i_total_freq,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_out_bit,
    output logic [ae31_pkg::FOLLOW_W-1:0] o_follow_count,
    output logic                          o_error,
    output logic                          o_last
);
    import ae31_pkg::*;

    t_req push_req;
    t_req head_req;
    logic push;
    logic full;
    logic head_valid;
    logic pop;

    ae31_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_low_count  (i_low_count),
        .i_high_count (i_high_count),
        .i_total_freq (i_total_freq),
        .i_full       (full),
        .o_push       (push),
        .o_req        (push_req)
    );

    ae31_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_req  (push_req),
        .o_full (full),
        .o_valid(head_valid),
        .i_pop  (pop),
        .o_req  (head_req)
    );

    ae31_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (head_valid),
        .i_q_req       (head_req),
        .o_q_pop       (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_bit     (o_out_bit),
        .o_follow_count(o_follow_count),
        .o_error       (o_error),
        .o_last        (o_last)
    );

endmodule

// ===== sv/ae31_front.sv =====
module ae31_front #(
    parameter int COUNT_BITS = ae31_pkg::COUNT_BITS_DEF
) (
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_cmd,
    input  logic [ae31_pkg::CNT_W-1:0] i_low_count,
    input  logic [ae31_pkg::CNT_W-1:0] i_high_count,
    input  logic [ae31_pkg::CNT_W-1:0] i_total_freq,
    input  logic                      i_full,
    output logic                      o_push,
    output ae31_pkg::t_req            o_req
);
    import ae31_pkg::*;

    localparam int LIM_W = COUNT_BITS + 1;
    localparam logic [LIM_W-1:0] TC_LIMIT = LIM_W'(1) << COUNT_BITS;

    logic tc_over;

    // Accept whenever the queue has room.
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // The total may exceed the configured count width.
    assign tc_over = (LIM_W > CNT_W) ? (LIM_W'(i_total_freq) > TC_LIMIT)
                                     : (i_total_freq > CNT_W'(TC_LIMIT));

    // Classify the request so the back end only has to dispatch on its kind.
    always_comb begin
        o_req.low_count  = i_low_count;
        o_req.high_count = i_high_count;
        o_req.total_freq = i_total_freq;
        if (i_cmd == CMD_FLUSH) begin
            o_req.kind = KIND_FLUSH;
        end else if (i_low_count >= i_high_count || i_high_count > i_total_freq
                     || tc_over) begin
            o_req.kind = KIND_ERROR;
        end else begin
            o_req.kind = KIND_ENCODE;
        end
    end

endmodule

// ===== sv/ae31_queue.sv =====
module ae31_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ae31_pkg::t_req i_req,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output ae31_pkg::t_req o_req
);
    import ae31_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_req              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage for queued requests.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/ae31_back.sv =====
module ae31_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  ae31_pkg::t_req                i_q_req,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_out_bit,
    output logic [ae31_pkg::FOLLOW_W-1:0] o_follow_count,
    output logic                          o_error,
    output logic                          o_last
);
    import ae31_pkg::*;

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic logic [CNT_W+32-1:0] div_step(input logic [CNT_W-1:0] rem,
                                                     input logic [31:0] sh,
                                                     input logic [CNT_W-1:0] div);
        logic [CNT_W:0] rs;
        logic           ge;
        logic [CNT_W:0] diff;
        rs   = {rem, sh[31]};
        ge   = (rs >= {1'b0, div});
        diff = rs - {1'b0, div};
        return {ge ? diff[CNT_W-1:0] : rs[CNT_W-1:0], sh[30:0], ge};
    endfunction

    t_state r_state;
    t_state n_state;
    t_req   r_req;

    logic [IVL_W-1:0]    r_low;
    logic [IVL_W-1:0]    r_high;
    logic [FOLLOW_W-1:0] r_pend;
    logic [31:0]         r_range;
    logic [CNT_W-1:0]    r_rem_lo;
    logic [CNT_W-1:0]    r_rem_hi;
    logic [31:0]         r_sh_lo;
    logic [31:0]         r_sh_hi;
    logic [4:0]          r_cnt;
    logic [5:0]          r_iter;
    logic [5:0]          r_nres;
    logic                r_hold_v;
    logic                r_hold_bit;
    logic [FOLLOW_W-1:0] r_hold_follow;

    logic                r_o_valid;
    logic                r_o_bit;
    logic [FOLLOW_W-1:0] r_o_follow;
    logic                r_o_error;
    logic                r_o_last;

    logic [CNT_W-1:0]    mul_b;
    logic [CNT_W+32-1:0] prod;
    logic [CNT_W+32-1:0] step_lo;
    logic [CNT_W+32-1:0] step_hi;
    logic                out_free;
    logic                e1;
    logic                e2;
    logic                e3;
    logic                rn_done;
    logic                rn_emit;
    logic                rn_stall;

    // Output register control.
    logic                out_load;
    logic                out_bit;
    logic [FOLLOW_W-1:0] out_follow;
    logic                out_error;
    logic                out_last;
    logic                advance;

    assign out_free = !r_o_valid || i_ready;

    // Shared multiplier: range times the low count, then times the high count.
    assign mul_b = (r_state == ST_MUL_LO) ? r_req.low_count : r_req.high_count;
    assign prod  = r_range * mul_b;

    assign step_lo = div_step(r_rem_lo, r_sh_lo, r_req.total_freq);
    assign step_hi = div_step(r_rem_hi, r_sh_hi, r_req.total_freq);

    // Renormalization conditions for the current interval.
    assign e1       = (r_high < Q_HALF);
    assign e2       = (r_low >= Q_HALF);
    assign e3       = (r_low >= Q_FIRST) && (r_high < Q_THIRD);
    assign rn_done  = (r_iter == MAX_ITER) || !(e1 || e2 || e3);
    assign rn_emit  = (e1 || e2) && (r_nres < MAX_RES);
    assign rn_stall = rn_emit && r_hold_v && !out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_req.kind)
                        KIND_FLUSH: n_state = ST_FLUSH;
                        KIND_ERROR: n_state = ST_ERROR;
                        default:    n_state = ST_MUL_LO;
                    endcase
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_RENORM;
            ST_RENORM: begin
                if (rn_done) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                if (!r_hold_v || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH, ST_ERROR: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control strobes and the result that goes to the output register.
    always_comb begin
        o_q_pop    = 1'b0;
        out_load   = 1'b0;
        out_bit    = r_hold_bit;
        out_follow = r_hold_follow;
        out_error  = 1'b0;
        out_last   = 1'b0;
        advance    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_q_pop = i_q_valid;
            ST_RENORM: begin
                advance  = !rn_done && !rn_stall;
                out_load = !rn_done && rn_emit && r_hold_v && out_free;
            end
            ST_LAST: begin
                out_load = r_hold_v && out_free;
                out_last = 1'b1;
            end
            ST_FLUSH: begin
                out_load   = out_free;
                out_bit    = (r_low >= Q_FIRST);
                out_follow = (r_pend == PEND_MAX) ? PEND_MAX : r_pend + 1'b1;
                out_last   = 1'b1;
            end
            ST_ERROR: begin
                out_load   = out_free;
                out_bit    = 1'b0;
                out_follow = '0;
                out_error  = 1'b1;
                out_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request latch, multiplier results and the two dividers running side by side.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid) begin
            r_req   <= i_q_req;
            r_range <= {1'b0, r_high} - {1'b0, r_low} + 32'd1;
        end
        if (r_state == ST_MUL_LO) begin
            r_rem_lo <= prod[CNT_W+32-1:32];
            r_sh_lo  <= prod[31:0];
        end
        if (r_state == ST_MUL_HI) begin
            r_rem_hi <= prod[CNT_W+32-1:32];
            r_sh_hi  <= prod[31:0];
            r_cnt    <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem_lo <= step_lo[CNT_W+32-1:32];
            r_sh_lo  <= step_lo[31:0];
            r_rem_hi <= step_hi[CNT_W+32-1:32];
            r_sh_hi  <= step_hi[31:0];
            r_cnt    <= r_cnt + 1'b1;
        end
    end

    // Coder state: interval narrowing, renormalization and flush.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low    <= '0;
            r_high   <= MASK31;
            r_pend   <= '0;
            r_iter   <= '0;
            r_nres   <= '0;
            r_hold_v <= 1'b0;
        end else begin
            unique case (r_state)
                ST_UPDATE: begin
                    r_low    <= r_low + r_sh_lo[IVL_W-1:0];
                    r_high   <= r_low + r_sh_hi[IVL_W-1:0] - 31'd1;
                    r_iter   <= '0;
                    r_nres   <= '0;
                    r_hold_v <= 1'b0;
                end
                ST_RENORM: begin
                    if (advance) begin
                        r_iter <= r_iter + 1'b1;
                        if (e1) begin
                            r_pend <= '0;
                            r_low  <= {r_low[IVL_W-2:0], 1'b0};
                            r_high <= {r_high[IVL_W-2:0], 1'b1};
                        end else if (e2) begin
                            r_pend <= '0;
                            r_low  <= {r_low[IVL_W-2:0] - Q_HALF[IVL_W-2:0], 1'b0};
                            r_high <= {r_high[IVL_W-2:0] - Q_HALF[IVL_W-2:0], 1'b1};
                        end else begin
                            if (r_pend != PEND_MAX) begin
                                r_pend <= r_pend + 1'b1;
                            end
                            r_low  <= {r_low[IVL_W-2:0] - Q_FIRST[IVL_W-2:0], 1'b0};
                            r_high <= {r_high[IVL_W-2:0] - Q_FIRST[IVL_W-2:0], 1'b1};
                        end
                        if (rn_emit) begin
                            r_hold_v      <= 1'b1;
                            r_hold_bit    <= !e1;
                            r_hold_follow <= r_pend;
                            r_nres        <= r_nres + 1'b1;
                        end
                    end
                end
                ST_LAST: begin
                    if (out_free) begin
                        r_hold_v <= 1'b0;
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        r_low  <= '0;
                        r_high <= MASK31;
                        r_pend <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: a held result waits here while the coder moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_bit    <= out_bit;
            r_o_follow <= out_follow;
            r_o_error  <= out_error;
            r_o_last   <= out_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_bit      = r_o_bit;
    assign o_follow_count = r_o_follow;
    assign o_error        = r_o_error;
    assign o_last         = r_o_last;

`include "arithmetic_encoder_31bit_assert.svh"

    `AE31_ALWAYS(a_nres_cap, i_clk, i_rst_n, r_nres <= MAX_RES, "result count above cap")
    `AE31_ALWAYS(a_idle_no_hold, i_clk, i_rst_n, !(r_state == ST_IDLE && r_hold_v), "held result left in idle")
    `AE31_ALWAYS(a_interval_order, i_clk, i_rst_n, !(r_state == ST_RENORM && r_low > r_high), "interval inverted")
    `AE31_IMPLIES_NEXT(a_flush_resets, i_clk, i_rst_n, r_state == ST_FLUSH && out_free, r_low == '0 && r_high == MASK31 && r_pend == '0, "flush did not reset coder")

endmodule
